[design/bc_texture_block_decoder_defines.svh]
// ----------------------------------------------------------------------------
// Block texture decoder assertion macros
// Shared concurrent assertion forms used by the decoder top level.
// ----------------------------------------------------------------------------
`ifndef BC_TEXTURE_BLOCK_DECODER_DEFINES_SVH
`define BC_TEXTURE_BLOCK_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCTD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/bctd_pkg.sv]
// ----------------------------------------------------------------------------
// Block texture decoder package
// Shared types, codes and small arithmetic helpers for the BC1/BC2/BC3 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bctd_pkg;

  localparam logic [1:0] FMT_BC1 = 2'd0;
  localparam logic [1:0] FMT_BC2 = 2'd1;
  localparam logic [1:0] FMT_BC3 = 2'd2;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LUM    = 4'd3;

  localparam int DIM_REG_W = 15;
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = 2;

  typedef struct packed {
    logic [DIM_REG_W-1:0] width;
    logic [DIM_REG_W-1:0] height;
    logic [1:0]           mode;
    logic                 lum;
  } cfg_t;

  typedef struct packed {
    logic        four_col;
    logic [7:0]  r0;
    logic [7:0]  g0;
    logic [7:0]  b0;
    logic [7:0]  r1;
    logic [7:0]  g1;
    logic [7:0]  b1;
    logic [31:0] cidx;
    logic [63:0] ablk;
    logic [11:0] bx;
    logic [11:0] by;
    logic [2:0]  nx;
    logic [2:0]  ny;
    logic        final_blk;
  } blk_desc_t;

  typedef struct packed {
    logic [13:0] x;
    logic [13:0] y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic        last_blk;
    logic        last_img;
  } pix_t;

  // c * 255 / 31 written as 8c + floor(7c / 31).
  function automatic logic [7:0] exp5(input logic [4:0] c);
    logic [7:0]  c7;
    logic [16:0] p;
    c7 = 8'(c) * 8'd7;
    p  = 17'(c7) * 17'd265;
    return 8'({c, 3'b000}) + 8'(p >> 13);
  endfunction

  // c * 255 / 63 written as 4c + floor(c / 21).
  function automatic logic [7:0] exp6(input logic [5:0] c);
    logic [11:0] p;
    p = 12'(c) * 12'd49;
    return 8'({c, 2'b00}) + 8'(p >> 10);
  endfunction

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd683;
    return 8'(p >> 11);
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd2341;
    return 8'(p >> 14);
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd3277;
    return 8'(p >> 14);
  endfunction

endpackage

`default_nettype wire

[design/bctd_front.sv]
// ----------------------------------------------------------------------------
// Block texture decoder front end
// Accepts compressed blocks, tracks the block position, clips against the
// image and queues a descriptor for every block that has in-image pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module bctd_front
  import bctd_pkg::*;
#(
  parameter int MAX_DIM = 16384
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire cfg_t         cfg,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,
  input  wire logic         q_full,
  output logic              q_push,
  output blk_desc_t         q_desc
);

  localparam int EW   = $clog2(MAX_DIM + 1);
  localparam int BMAX = (MAX_DIM + 3) / 4;
  localparam int CW   = (BMAX > 1) ? $clog2(BMAX) : 1;
  localparam int DW   = ((CW + 2) > EW) ? (CW + 2) : EW;

  logic [EW-1:0] w_eff, h_eff;
  logic [EW:0]   w_sum, h_sum;
  logic [CW:0]   bw, bh;
  logic [CW-1:0] col_r, row_r, col_nxt, row_nxt;
  logic [CW:0]   col_inc, row_inc;
  logic [DW-1:0] px0, py0, wd, hd, dx, dy;
  logic [2:0]    nx, ny;
  logic [15:0]   c0, c1;
  logic          accept;

  always_comb begin
    if (cfg.width == '0) begin
      w_eff = EW'(1);
    end else if (32'(cfg.width) > 32'(MAX_DIM)) begin
      w_eff = EW'(MAX_DIM);
    end else begin
      w_eff = EW'(cfg.width);
    end
    if (cfg.height == '0) begin
      h_eff = EW'(1);
    end else if (32'(cfg.height) > 32'(MAX_DIM)) begin
      h_eff = EW'(MAX_DIM);
    end else begin
      h_eff = EW'(cfg.height);
    end
  end

  assign w_sum = (EW+1)'(w_eff) + (EW+1)'(3);
  assign h_sum = (EW+1)'(h_eff) + (EW+1)'(3);
  assign bw    = (CW+1)'(w_sum >> 2);
  assign bh    = (CW+1)'(h_sum >> 2);

  assign col_inc = (CW+1)'(col_r) + (CW+1)'(1);
  assign row_inc = (CW+1)'(row_r) + (CW+1)'(1);

  assign px0 = DW'({col_r, 2'b00});
  assign py0 = DW'({row_r, 2'b00});
  assign wd  = DW'(w_eff);
  assign hd  = DW'(h_eff);
  assign dx  = wd - px0;
  assign dy  = hd - py0;

  always_comb begin
    if (px0 >= wd) begin
      nx = 3'd0;
    end else if (dx >= DW'(4)) begin
      nx = 3'd4;
    end else begin
      nx = dx[2:0];
    end
    if (py0 >= hd) begin
      ny = 3'd0;
    end else if (dy >= DW'(4)) begin
      ny = 3'd4;
    end else begin
      ny = dy[2:0];
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (col_inc >= bw) begin
      col_nxt = '0;
      if (row_inc >= bh) begin
        row_nxt = '0;
      end else begin
        row_nxt = row_inc[CW-1:0];
      end
    end else begin
      col_nxt = col_inc[CW-1:0];
    end
  end

  assign c0        = in_tdata[15:0];
  assign c1        = in_tdata[31:16];
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept && (nx != 3'd0) && (ny != 3'd0);

  always_comb begin
    q_desc.four_col  = (cfg.mode != FMT_BC1) || (c0 > c1);
    q_desc.r0        = exp5(c0[15:11]);
    q_desc.g0        = exp6(c0[10:5]);
    q_desc.b0        = exp5(c0[4:0]);
    q_desc.r1        = exp5(c1[15:11]);
    q_desc.g1        = exp6(c1[10:5]);
    q_desc.b1        = exp5(c1[4:0]);
    q_desc.cidx      = in_tdata[63:32];
    q_desc.ablk      = in_tdata[127:64];
    q_desc.bx        = 12'(col_r);
    q_desc.by        = 12'(row_r);
    q_desc.nx        = nx;
    q_desc.ny        = ny;
    q_desc.final_blk = (col_inc == bw) && (row_inc == bh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

[design/bctd_queue.sv]
// ----------------------------------------------------------------------------
// Block texture decoder descriptor queue
// Short first-in first-out buffer between the front end and the pixel engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bctd_queue
  import bctd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire blk_desc_t push_desc,
  input  wire logic      pop,
  output blk_desc_t      head_desc,
  output logic           full,
  output logic           empty
);

  blk_desc_t         entry_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]     count_r;
  logic              do_push, do_pop;

  assign full      = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign empty     = (count_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_desc = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (Q_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (Q_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

[design/bctd_back.sv]
// ----------------------------------------------------------------------------
// Block texture decoder pixel engine
// Builds the colour and alpha palettes of a queued block, walks its in-image
// pixels one per cycle unless stalled; if lum is on, alpha becomes luminance.
// ----------------------------------------------------------------------------
`default_nettype none

module bctd_back
  import bctd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        q_empty,
  input  wire blk_desc_t   q_head,
  output logic             q_pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,
  output logic             out_tlast,
  output logic             out_tuser
);

  logic        en;
  logic        blk_valid_r;
  blk_desc_t   blk_r;
  logic [1:0]  x_r, y_r;
  logic [7:0]  pal_r_r [4];
  logic [7:0]  pal_g_r [4];
  logic [7:0]  pal_b_r [4];
  logic [7:0]  pal_a_r [8];
  logic [7:0]  np_r [4];
  logic [7:0]  np_g [4];
  logic [7:0]  np_b [4];
  logic [7:0]  np_a [8];
  logic        blk_done;
  logic [3:0]  pix_idx;
  logic [1:0]  ci;
  logic [5:0]  aidx_pos;
  logic [3:0]  nib;
  pix_t        s1_nxt;

  logic        s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  pix_t        s1_r, s2_r, s3_r, s4_r;
  pix_t        s4_nxt;
  logic [17:0] s2_sum_r, s3_sum_r;
  logic [17:0] sum_nxt;
  logic [28:0] q_prod;
  logic [7:0]  s3_q_r;
  logic [17:0] rem;
  logic [7:0]  q_fix;

  assign en       = !s4_valid_r || out_tready;
  assign blk_done = blk_valid_r && ({1'b0, x_r} == (blk_r.nx - 3'd1))
                    && ({1'b0, y_r} == (blk_r.ny - 3'd1));
  assign q_pop    = en && (!blk_valid_r || blk_done) && !q_empty;

  always_comb begin
    np_r[0] = q_head.r0;
    np_g[0] = q_head.g0;
    np_b[0] = q_head.b0;
    np_r[1] = q_head.r1;
    np_g[1] = q_head.g1;
    np_b[1] = q_head.b1;
    if (q_head.four_col) begin
      np_r[2] = div3(10'({q_head.r0, 1'b0}) + 10'(q_head.r1));
      np_g[2] = div3(10'({q_head.g0, 1'b0}) + 10'(q_head.g1));
      np_b[2] = div3(10'({q_head.b0, 1'b0}) + 10'(q_head.b1));
      np_r[3] = div3(10'(q_head.r0) + 10'({q_head.r1, 1'b0}));
      np_g[3] = div3(10'(q_head.g0) + 10'({q_head.g1, 1'b0}));
      np_b[3] = div3(10'(q_head.b0) + 10'({q_head.b1, 1'b0}));
    end else begin
      np_r[2] = 8'((9'(q_head.r0) + 9'(q_head.r1)) >> 1);
      np_g[2] = 8'((9'(q_head.g0) + 9'(q_head.g1)) >> 1);
      np_b[2] = 8'((9'(q_head.b0) + 9'(q_head.b1)) >> 1);
      np_r[3] = 8'd0;
      np_g[3] = 8'd0;
      np_b[3] = 8'd0;
    end
  end

  always_comb begin
    np_a[0] = q_head.ablk[7:0];
    np_a[1] = q_head.ablk[15:8];
    for (int k = 1; k <= 6; k++) begin
      if (q_head.ablk[7:0] > q_head.ablk[15:8]) begin
        np_a[k+1] = div7(11'(7 - k) * 11'(q_head.ablk[7:0])
                         + 11'(k) * 11'(q_head.ablk[15:8]));
      end else if (k <= 4) begin
        np_a[k+1] = div5(11'(5 - k) * 11'(q_head.ablk[7:0])
                         + 11'(k) * 11'(q_head.ablk[15:8]));
      end else if (k == 5) begin
        np_a[k+1] = 8'd0;
      end else begin
        np_a[k+1] = 8'd255;
      end
    end
  end

  assign pix_idx  = {y_r, x_r};
  assign ci       = blk_r.cidx[{pix_idx, 1'b0} +: 2];
  assign aidx_pos = 6'd16 + 6'(pix_idx) * 6'd3;
  assign nib      = blk_r.ablk[{pix_idx, 2'b00} +: 4];

  always_comb begin
    s1_nxt.x        = 14'({blk_r.bx, x_r});
    s1_nxt.y        = 14'({blk_r.by, y_r});
    s1_nxt.r        = pal_r_r[ci];
    s1_nxt.g        = pal_g_r[ci];
    s1_nxt.b        = pal_b_r[ci];
    s1_nxt.last_blk = blk_done;
    s1_nxt.last_img = blk_done && blk_r.final_blk;
    unique case (cfg.mode)
      FMT_BC1: begin
        s1_nxt.a = (ci == 2'd3 && !blk_r.four_col) ? 8'd0 : 8'd255;
      end
      FMT_BC2: begin
        s1_nxt.a = {nib, nib};
      end
      default: begin
        s1_nxt.a = pal_a_r[blk_r.ablk[aidx_pos +: 3]];
      end
    endcase
  end

  assign sum_nxt = 18'(s1_r.r) * 18'd299 + 18'(s1_r.g) * 18'd587
                 + 18'(s1_r.b) * 18'd114;
  assign q_prod  = 29'(s2_sum_r) * 29'd1048;
  assign rem     = s3_sum_r - 18'(s3_q_r) * 18'd1000;
  assign q_fix   = (rem >= 18'd1000) ? (s3_q_r + 8'd1) : s3_q_r;

  always_comb begin
    s4_nxt = s3_r;
    if (cfg.lum) begin
      s4_nxt.a = q_fix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_valid_r <= 1'b0;
      x_r         <= '0;
      y_r         <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
    end else if (en) begin
      if (q_pop) begin
        blk_valid_r <= 1'b1;
        x_r         <= '0;
        y_r         <= '0;
      end else if (blk_done) begin
        blk_valid_r <= 1'b0;
      end else if (blk_valid_r) begin
        if ({1'b0, x_r} == (blk_r.nx - 3'd1)) begin
          x_r <= '0;
          y_r <= y_r + 2'd1;
        end else begin
          x_r <= x_r + 2'd1;
        end
      end
      s1_valid_r <= blk_valid_r;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      blk_r   <= q_head;
      pal_r_r <= np_r;
      pal_g_r <= np_g;
      pal_b_r <= np_b;
      pal_a_r <= np_a;
    end
    if (en) begin
      s1_r     <= s1_nxt;
      s2_r     <= s1_r;
      s2_sum_r <= sum_nxt;
      s3_r     <= s2_r;
      s3_sum_r <= s2_sum_r;
      s3_q_r   <= 8'(q_prod >> 20);
      s4_r     <= s4_nxt;
    end
  end

  assign out_tvalid = s4_valid_r;
  assign out_tdata  = {4'b0000, s4_r.a, s4_r.b, s4_r.g, s4_r.r, s4_r.y, s4_r.x};
  assign out_tlast  = s4_r.last_blk;
  assign out_tuser  = s4_r.last_img;

endmodule

`default_nettype wire

[design/bc_texture_block_decoder.sv]
// ----------------------------------------------------------------------------
// Block texture decoder top level
// BC1/BC2/BC3 block decompression to 8-bit RGBA pixels in block order.
// ----------------------------------------------------------------------------
// Each input transaction carries one compressed 4x4 block, in raster block
// order over the image. The block keeps its own block column and row, and
// both return to zero after the last block of the image.
// Each output transaction carries one in-image pixel of a block, row by row
// and left to right; tlast marks the last pixel of a block and tuser the
// last pixel of the image. Blocks wholly outside the image yield nothing.
// The first pixel of a block passes through the descriptor queue, the block
// register and pipeline stages s1 to s4. The pixel engine produces one pixel
// per cycle while blocks are queued and the receiver does not stall; the
// front end takes one block per cycle while the four-entry descriptor queue
// has room.
// When the receiver stalls, the pixel pipeline holds, the queue fills and
// then in_tready drops. Reset clears the position, the queue and the
// pipeline and loads width 4, height 4, BC1 and luminance alpha off.
// Configuration must be written only while no transaction is in flight; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bc_texture_block_decoder_defines.svh"

module bc_texture_block_decoder
  import bctd_pkg::*;
#(
  parameter int MAX_DIM = 16384
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_REG_W-1:0] cfg_wdata,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // [63:0] color_block, [127:64] alpha_block
  input  wire logic [127:0]         in_tdata,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // [13:0] pixel_x, [27:14] pixel_y, [35:28] red, [43:36] green,
  // [51:44] blue, [59:52] alpha, [63:60] zero
  output logic [63:0]               out_tdata,
  output logic                      out_tlast,
  // [0] last_in_image
  output logic                      out_tuser
);

  logic [DIM_REG_W-1:0] width_r, height_r;
  logic [1:0]           mode_r;
  logic                 lum_r;
  cfg_t                 cfg;
  logic                 q_push, q_pop, q_full, q_empty;
  blk_desc_t            q_in, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_REG_W'(4);
      height_r <= DIM_REG_W'(4);
      mode_r   <= FMT_BC1;
      lum_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_wdata;
        CFG_HEIGHT: height_r <= cfg_wdata;
        CFG_FORMAT: mode_r   <= cfg_wdata[1:0];
        CFG_LUM:    lum_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.width  = width_r;
    cfg.height = height_r;
    cfg.mode   = mode_r;
    cfg.lum    = lum_r;
  end

  bctd_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (q_in)
  );

  bctd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_in),
    .pop       (q_pop),
    .head_desc (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  bctd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  `BCTD_ASSERT_SAME(a_push_not_full, q_push, !q_full, "descriptor pushed into a full queue")
  `BCTD_ASSERT_SAME(a_pop_not_empty, q_pop, !q_empty, "descriptor popped from an empty queue")
  `BCTD_ASSERT_SAME(a_image_end_ends_block, out_tvalid && out_tuser, out_tlast,
                    "image end flagged on a pixel that does not end its block")
  `BCTD_ASSERT_NEXT(a_full_blocks_input, q_full && !q_pop, !in_tready || !q_full,
                    "queue overflow risk after a full cycle without a pop")

endmodule

`default_nettype wire
